@@ hdl/aisenc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AIS sentence encoder package
// Shared constants, widths and the command record passed from front to back.
// ----------------------------------------------------------------------------
package aisenc_pkg;

  localparam int MAX_PACKET_BITS    = 1024;
  localparam int CHARS_PER_SENTENCE = 56;

  localparam int GROUPS_CAP   = 1530;
  localparam int SENTENCE_CAP = 42 * CHARS_PER_SENTENCE;
  localparam int CAP_A        = (MAX_PACKET_BITS < GROUPS_CAP) ? MAX_PACKET_BITS : GROUPS_CAP;
  localparam int BITS_CAP     = (CAP_A < SENTENCE_CAP) ? CAP_A : SENTENCE_CAP;

  localparam int BIT_W   = 11;
  localparam int SIX_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int GROUP_W = 8;
  localparam int CHARS_W = 6;
  localparam int IDX_W   = 3;
  localparam int SEQ_W   = 4;
  localparam int FILL_W  = 3;
  localparam int STEP_W  = 4;

  // Division by six through a reciprocal, exact for values up to BITS_CAP plus five.
  localparam int DIV6_MUL   = 683;
  localparam int DIV6_SHIFT = 12;
  localparam int PROD_W     = BIT_W + 10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam int SEQ_MAX     = 9;
  localparam int ARMOUR_KNEE = 40;
  localparam int ASCII_ZERO  = 48;
  localparam int ARMOUR_HIGH = 56;

  typedef enum logic {
    OP_START,
    OP_GROUP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic              close;
    logic              fin;
    logic              hdr;
    logic [IDX_W-1:0]  total;
    logic [IDX_W-1:0]  index;
    logic [SEQ_W-1:0]  seq;
    logic [CHAR_W-1:0] channel;
    logic [FILL_W-1:0] fill;
  } cmd_t;

endpackage
`default_nettype wire

@@ hdl/aisenc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AIS sentence encoder front end
// Accepts beats, tracks packets; one command per start or in-packet group.
// ----------------------------------------------------------------------------
module aisenc_front import aisenc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [BIT_W-1:0]  bit_count,
  input  logic [CHAR_W-1:0] channel_letter,
  input  logic [SIX_W-1:0]  six_bits,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd
);

  logic [SEQ_W-1:0]   seq;
  logic [GROUP_W-1:0] groups_left;
  logic [IDX_W-1:0]   total;
  logic [IDX_W-1:0]   index;
  logic [CHARS_W-1:0] chars;
  logic [FILL_W-1:0]  fill;
  logic [CHAR_W-1:0]  channel;
  logic               open;

  logic               accept;
  logic [BIT_W-1:0]   bits_cl;
  logic [BIT_W-1:0]   bits_p5;
  logic [PROD_W-1:0]  prod;
  logic [GROUP_W-1:0] groups;
  logic [BIT_W-1:0]   six_x;
  logic [IDX_W-1:0]   total_new;
  logic [SEQ_W-1:0]   seq_new;
  logic [FILL_W-1:0]  fill_new;
  logic [CHAR_W-1:0]  armoured;
  logic [GROUP_W-1:0] gl_dec;
  logic [CHARS_W-1:0] chars_inc;
  logic               g_fin;
  logic               g_close;
  logic               g_hdr;
  logic [IDX_W-1:0]   index_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    bits_cl  = (bit_count > BIT_W'(BITS_CAP)) ? BIT_W'(BITS_CAP) : bit_count;
    bits_p5  = bits_cl + BIT_W'(5);
    prod     = PROD_W'(bits_p5) * PROD_W'(DIV6_MUL);
    groups   = prod[DIV6_SHIFT +: GROUP_W];
    six_x    = (BIT_W'(groups) << 2) + (BIT_W'(groups) << 1);
    fill_new = FILL_W'(six_x - bits_cl);
  end

  always_comb begin
    total_new = IDX_W'(1);
    for (int k = 1; k < 7; k++) begin
      if ({2'b00, groups} > 10'(k * CHARS_PER_SENTENCE)) begin
        total_new = total_new + IDX_W'(1);
      end
    end
  end

  always_comb begin
    seq_new = seq;
    if (total_new > IDX_W'(1)) begin
      seq_new = (seq == SEQ_W'(SEQ_MAX)) ? '0 : seq + SEQ_W'(1);
    end
    armoured  = CHAR_W'(six_bits) + ((six_bits < SIX_W'(ARMOUR_KNEE)) ?
                CHAR_W'(ASCII_ZERO) : CHAR_W'(ARMOUR_HIGH));
    gl_dec    = groups_left - GROUP_W'(1);
    chars_inc = chars + CHARS_W'(1);
    g_fin     = (gl_dec == '0);
    g_close   = g_fin || (chars_inc >= CHARS_W'(CHARS_PER_SENTENCE));
    g_hdr     = g_close && !g_fin;
    index_new = g_hdr ? index + IDX_W'(1) : index;
  end

  always_comb begin
    push     = accept && ((action == OP_START) || open);
    push_cmd = '0;
    if (action == OP_START) begin
      push_cmd.op      = OP_START;
      push_cmd.close   = (groups == '0);
      push_cmd.fin     = 1'b1;
      push_cmd.hdr     = 1'b1;
      push_cmd.total   = total_new;
      push_cmd.index   = IDX_W'(1);
      push_cmd.seq     = seq_new;
      push_cmd.channel = channel_letter;
      push_cmd.fill    = fill_new;
    end else begin
      push_cmd.op      = OP_GROUP;
      push_cmd.ch      = armoured;
      push_cmd.close   = g_close;
      push_cmd.fin     = g_fin;
      push_cmd.hdr     = g_hdr;
      push_cmd.total   = total;
      push_cmd.index   = index_new;
      push_cmd.seq     = seq;
      push_cmd.channel = channel;
      push_cmd.fill    = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= '0;
      groups_left <= '0;
      total       <= '0;
      index       <= '0;
      chars       <= '0;
      fill        <= '0;
      channel     <= '0;
      open        <= 1'b0;
    end else if (accept) begin
      if (action == OP_START) begin
        seq         <= seq_new;
        groups_left <= groups;
        total       <= total_new;
        index       <= IDX_W'(1);
        chars       <= '0;
        fill        <= fill_new;
        channel     <= channel_letter;
        open        <= (groups != '0);
      end else if (open) begin
        groups_left <= gl_dec;
        index       <= index_new;
        chars       <= g_hdr ? '0 : chars_inc;
        open        <= !g_fin;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/aisenc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AIS sentence encoder command queue
// Short first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
module aisenc_queue import aisenc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/aisenc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AIS sentence encoder back end
// Expands each command into characters, keeps the checksum, drives the output.
// ----------------------------------------------------------------------------
module aisenc_back import aisenc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cmd_t              head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] character,
  output logic              sentence_end,
  output logic              packet_end,
  output logic              last
);

  typedef enum logic [1:0] {
    PH_CHAR,
    PH_HDR,
    PH_TRL
  } phase_t;

  localparam logic [STEP_W-1:0] HS_BANG      = 4'd0;
  localparam logic [STEP_W-1:0] HS_A         = 4'd1;
  localparam logic [STEP_W-1:0] HS_I         = 4'd2;
  localparam logic [STEP_W-1:0] HS_V         = 4'd3;
  localparam logic [STEP_W-1:0] HS_D         = 4'd4;
  localparam logic [STEP_W-1:0] HS_M         = 4'd5;
  localparam logic [STEP_W-1:0] HS_COMMA1    = 4'd6;
  localparam logic [STEP_W-1:0] HS_TOTAL     = 4'd7;
  localparam logic [STEP_W-1:0] HS_COMMA2    = 4'd8;
  localparam logic [STEP_W-1:0] HS_INDEX     = 4'd9;
  localparam logic [STEP_W-1:0] HS_COMMA3    = 4'd10;
  localparam logic [STEP_W-1:0] HS_SEQ       = 4'd11;
  localparam logic [STEP_W-1:0] HS_COMMA4    = 4'd12;
  localparam logic [STEP_W-1:0] HS_CHANNEL   = 4'd13;
  localparam logic [STEP_W-1:0] HS_COMMA5    = 4'd14;
  localparam logic [STEP_W-1:0] TS_COMMA     = 4'd0;
  localparam logic [STEP_W-1:0] TS_FILL      = 4'd1;
  localparam logic [STEP_W-1:0] TS_STAR      = 4'd2;
  localparam logic [STEP_W-1:0] TS_HEX_HI    = 4'd3;
  localparam logic [STEP_W-1:0] TS_HEX_LO    = 4'd4;

  phase_t              phase;
  logic [STEP_W-1:0]   step;
  logic                begun;
  logic [CHAR_W-1:0]   csum;

  phase_t              cur_phase;
  logic [STEP_W-1:0]   cur_step;
  phase_t              phase_next;
  logic [STEP_W-1:0]   step_next;
  logic                done;
  logic                emit;
  logic                summed;
  logic [CHAR_W-1:0]   ch;
  logic                s_end;
  logic                p_end;

  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? CHAR_W'(v) + 8'h30 : CHAR_W'(v) + 8'h37;
  endfunction

  assign emit = head_valid && (!out_valid || out_ready);
  assign pop  = emit && done;

  always_comb begin
    cur_phase = begun ? phase : ((head.op == OP_START) ? PH_HDR : PH_CHAR);
    cur_step  = begun ? step : '0;
  end

  always_comb begin
    ch         = 8'h2C;
    summed     = 1'b0;
    s_end      = 1'b0;
    p_end      = 1'b0;
    done       = 1'b0;
    phase_next = cur_phase;
    step_next  = cur_step + STEP_W'(1);
    unique case (cur_phase)
      PH_CHAR: begin
        ch         = head.ch;
        summed     = 1'b1;
        phase_next = PH_TRL;
        step_next  = '0;
        done       = !head.close;
      end
      PH_HDR: begin
        summed = (cur_step != HS_BANG);
        unique case (cur_step)
          HS_BANG:    ch = 8'h21;
          HS_A:       ch = 8'h41;
          HS_I:       ch = 8'h49;
          HS_V:       ch = 8'h56;
          HS_D:       ch = 8'h44;
          HS_M:       ch = 8'h4D;
          HS_TOTAL:   ch = CHAR_W'(head.total) + CHAR_W'(ASCII_ZERO);
          HS_INDEX:   ch = CHAR_W'(head.index) + CHAR_W'(ASCII_ZERO);
          HS_SEQ:     ch = CHAR_W'(head.seq) + CHAR_W'(ASCII_ZERO);
          HS_CHANNEL: ch = head.channel;
          default:    ch = 8'h2C;
        endcase
        if (cur_step == HS_COMMA3 && head.total <= IDX_W'(1)) begin
          step_next = HS_COMMA4;
        end
        if (cur_step == HS_COMMA5) begin
          phase_next = PH_TRL;
          step_next  = '0;
          done       = (head.op == OP_GROUP) || !head.close;
        end
      end
      PH_TRL: begin
        unique case (cur_step)
          TS_COMMA: begin
            ch     = 8'h2C;
            summed = 1'b1;
          end
          TS_FILL: begin
            ch     = head.fin ? CHAR_W'(head.fill) + CHAR_W'(ASCII_ZERO) : CHAR_W'(ASCII_ZERO);
            summed = 1'b1;
          end
          TS_STAR:   ch = 8'h2A;
          TS_HEX_HI: ch = hex_digit(csum[7:4]);
          default:   ch = hex_digit(csum[3:0]);
        endcase
        if (cur_step == TS_HEX_LO) begin
          s_end      = 1'b1;
          p_end      = head.fin;
          phase_next = PH_HDR;
          step_next  = '0;
          done       = !((head.op == OP_GROUP) && head.hdr);
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CHAR;
      step      <= '0;
      begun     <= 1'b0;
      csum      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        begun     <= !done;
        phase     <= phase_next;
        step      <= step_next;
        if (cur_phase == PH_HDR && cur_step == HS_BANG) begin
          csum <= '0;
        end else if (summed) begin
          csum <= csum ^ ch;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character    <= ch;
      sentence_end <= s_end;
      packet_end   <= p_end;
      last         <= done;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ais_nmea_sentence_encoder_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AIS NMEA sentence encoder
// Turns AIS packet start and six-bit group beats into an !AIVDM character stream.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid, in_ready   action, bit_count, channel_letter, six_bits
// out      out_valid, out_ready character, sentence_end, packet_end, last
//
// The front end takes one input beat per cycle while the four-entry command
// queue has room. The back end sends one character per cycle when not stalled:
// a payload group gives one character, six when it ends the packet, 21 when it
// ends a sentence and starts the next; a start beat gives 14 or 15 characters,
// 19 for an empty packet. Reset is synchronous and leaves no packet open.
// Output stalls hold the back end only; the queue lets the front end run on.
// ----------------------------------------------------------------------------
module ais_nmea_sentence_encoder_top import aisenc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [BIT_W-1:0]  bit_count,
  input  logic [CHAR_W-1:0] channel_letter,
  input  logic [SIX_W-1:0]  six_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] character,
  output logic              sentence_end,
  output logic              packet_end,
  output logic              last
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic head_valid;
  cmd_t head;
  logic pop;

  aisenc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .bit_count      (bit_count),
    .channel_letter (channel_letter),
    .six_bits       (six_bits),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  aisenc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  aisenc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .character    (character),
    .sentence_end (sentence_end),
    .packet_end   (packet_end),
    .last         (last)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// AIS NMEA sentence encoder testbench
// Sends packet start and six-bit group beats into the encoder. A behavioural
// encoder in this bench checks the resulting !AIVDM character stream
// character by character, under random gaps on both sides and a long output
// hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import aisenc_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              s_end;
    logic              p_end;
    logic              last;
  } nmea_char_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic              action         = OP_START;
  logic [BIT_W-1:0]  bit_count      = '0;
  logic [CHAR_W-1:0] channel_letter = '0;
  logic [SIX_W-1:0]  six_bits       = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [CHAR_W-1:0] character;
  logic              sentence_end;
  logic              packet_end;
  logic              last;

  ais_nmea_sentence_encoder_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .bit_count      (bit_count),
    .channel_letter (channel_letter),
    .six_bits       (six_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .character      (character),
    .sentence_end   (sentence_end),
    .packet_end     (packet_end),
    .last           (last)
  );

  always #5 clk = ~clk;

  // Encoder state as the bench sees it.
  logic [SEQ_W-1:0]   pk_seq         = '0;
  logic [GROUP_W-1:0] pk_groups_left = '0;
  logic [IDX_W-1:0]   pk_total       = '0;
  logic [IDX_W-1:0]   pk_index       = '0;
  logic [CHARS_W-1:0] pk_chars       = '0;
  logic [CHAR_W-1:0]  pk_xor         = '0;
  logic [FILL_W-1:0]  pk_fill        = '0;
  logic [CHAR_W-1:0]  pk_channel     = '0;
  logic               pk_open        = 1'b0;

  nmea_char_t sentence_chars_q[$];

  int errors        = 0;
  int items_sent    = 0;
  int starts_sent   = 0;
  int groups_sent   = 0;
  int strays_sent   = 0;
  int chars_checked = 0;
  int sentences     = 0;
  int packets_done  = 0;
  int sender_idle   = 0;
  int receiver_idle = 0;
  int hold_reqs     = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  function automatic int idle_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 9) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void emit_char(logic [CHAR_W-1:0] ch, logic s_end, logic p_end);
    nmea_char_t c;
    c.ch    = ch;
    c.s_end = s_end;
    c.p_end = p_end;
    c.last  = 1'b0;
    sentence_chars_q.insert(sentence_chars_q.size(), c);
  endfunction

  function automatic void emit_summed(logic [CHAR_W-1:0] ch);
    pk_xor = pk_xor ^ ch;
    emit_char(ch, 1'b0, 1'b0);
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? CHAR_W'(ASCII_ZERO) + CHAR_W'(v)
                       : CHAR_W'("A") + CHAR_W'(v) - CHAR_W'(10);
  endfunction

  function automatic void emit_header();
    string tag;
    tag      = "AIVDM,";
    pk_xor   = '0;
    pk_chars = '0;
    emit_char("!", 1'b0, 1'b0);
    for (int i = 0; i < tag.len(); i++) emit_summed(tag[i]);
    emit_summed(CHAR_W'(ASCII_ZERO) + CHAR_W'(pk_total));
    emit_summed(",");
    emit_summed(CHAR_W'(ASCII_ZERO) + CHAR_W'(pk_index));
    emit_summed(",");
    if (pk_total > IDX_W'(1)) emit_summed(CHAR_W'(ASCII_ZERO) + CHAR_W'(pk_seq));
    emit_summed(",");
    emit_summed(pk_channel);
    emit_summed(",");
  endfunction

  function automatic void emit_trailer(logic closing);
    emit_summed(",");
    emit_summed(closing ? CHAR_W'(ASCII_ZERO) + CHAR_W'(pk_fill) : CHAR_W'(ASCII_ZERO));
    emit_char("*", 1'b0, 1'b0);
    emit_char(hex_char(pk_xor[7:4]), 1'b0, 1'b0);
    emit_char(hex_char(pk_xor[3:0]), 1'b1, closing);
  endfunction

  function automatic int groups_for(int bits);
    return ((bits > BITS_CAP ? BITS_CAP : bits) + 5) / 6;
  endfunction

  // Works out the characters that one accepted input beat must produce.
  function automatic void encode_beat(op_t op, logic [BIT_W-1:0] bits,
                                      logic [CHAR_W-1:0] chan, logic [SIX_W-1:0] six);
    int n_groups;
    int clamped;
    int size_before;
    nmea_char_t tail;
    size_before = sentence_chars_q.size();
    if (op == OP_START) begin
      clamped  = (int'(bits) > BITS_CAP) ? BITS_CAP : int'(bits);
      n_groups = groups_for(int'(bits));
      pk_fill  = FILL_W'(n_groups * 6 - clamped);
      pk_total = (n_groups == 0) ? IDX_W'(1) :
                 IDX_W'((n_groups + CHARS_PER_SENTENCE - 1) / CHARS_PER_SENTENCE);
      if (pk_total > IDX_W'(1))
        pk_seq = (pk_seq >= SEQ_W'(SEQ_MAX)) ? '0 : pk_seq + SEQ_W'(1);
      pk_channel     = chan;
      pk_groups_left = GROUP_W'(n_groups);
      pk_index       = IDX_W'(1);
      pk_open        = 1'b1;
      emit_header();
      if (n_groups == 0) begin
        emit_trailer(1'b1);
        pk_open = 1'b0;
      end
    end else if (pk_open) begin
      emit_summed(CHAR_W'(six) + ((six < SIX_W'(ARMOUR_KNEE)) ?
                  CHAR_W'(ASCII_ZERO) : CHAR_W'(ARMOUR_HIGH)));
      pk_groups_left = pk_groups_left - GROUP_W'(1);
      pk_chars       = pk_chars + CHARS_W'(1);
      if (pk_groups_left == '0) begin
        emit_trailer(1'b1);
        pk_open = 1'b0;
      end else if (pk_chars >= CHARS_W'(CHARS_PER_SENTENCE)) begin
        emit_trailer(1'b0);
        pk_index = pk_index + IDX_W'(1);
        emit_header();
      end
    end
    if (sentence_chars_q.size() > size_before) begin
      tail      = sentence_chars_q[sentence_chars_q.size() - 1];
      tail.last = 1'b1;
      sentence_chars_q[sentence_chars_q.size() - 1] = tail;
    end
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // Input beats are predicted before output beats are checked, at the same edge.
  always @(posedge clk) begin : stream_checker
    nmea_char_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        encode_beat(op_t'(action), bit_count, channel_letter, six_bits);
      if (out_valid && out_ready) begin
        if (sentence_chars_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected character, expected none, actual %0h", $time, character);
        end else begin
          want = sentence_chars_q.pop_front();
          check_field("character", int'(want.ch), int'(character));
          check_field("sentence_end", int'(want.s_end), int'(sentence_end));
          check_field("packet_end", int'(want.p_end), int'(packet_end));
          check_field("last", int'(want.last), int'(last));
          chars_checked++;
          if (sentence_end) sentences++;
          if (packet_end) packets_done++;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      out_ready  <= 1'b0;
      holds_done <= hold_reqs;
      hold_left  <= LONG_HOLD;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      gap = idle_len(receiver_idle);
      if (gap > 0) begin
        out_ready  <= 1'b0;
        stall_left <= gap - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Valid is left high on return; the next call either lowers it for a gap or
  // replaces the payload in the same step.
  task automatic send_item(input op_t op, input logic [BIT_W-1:0] bits,
                           input logic [CHAR_W-1:0] chan, input logic [SIX_W-1:0] six,
                           input bit counted);
    int gap;
    gap = idle_len(sender_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= op;
    bit_count      <= bits;
    channel_letter <= chan;
    six_bits       <= six;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) items_sent++;
    if (op == OP_START) starts_sent++;
    else if (counted) groups_sent++;
    else strays_sent++;
  endtask

  task automatic send_packet(input int bits, input logic [CHAR_W-1:0] chan, input int n_groups);
    send_item(OP_START, BIT_W'(bits), chan, SIX_W'($urandom_range(63)), 1'b1);
    repeat (n_groups)
      send_item(OP_GROUP, BIT_W'($urandom_range(2047)), CHAR_W'($urandom_range(255)),
                SIX_W'($urandom_range(63)), 1'b1);
  endtask

  function automatic int pick_bits();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 75) return $urandom_range(60, 1);
    if (r < 90) return $urandom_range(400, 61);
    if (r < 96) return $urandom_range(1024, 401);
    return $urandom_range(2047, 1025);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_channel();
    if ($urandom_range(1)) return $urandom_range(1) ? CHAR_W'("A") : CHAR_W'("B");
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic test_directed_packets();
    sender_idle   = 20;
    receiver_idle = 20;
    send_item(OP_START, BIT_W'(0), "A", SIX_W'(63), 1'b1);
    send_item(OP_START, BIT_W'(1), "B", SIX_W'(0), 1'b1);
    send_item(OP_GROUP, BIT_W'(2047), CHAR_W'(255), SIX_W'(63), 1'b1);
    send_item(OP_GROUP, BIT_W'(0), CHAR_W'(0), SIX_W'(0), 1'b0);
    send_item(OP_START, BIT_W'(6), CHAR_W'(0), SIX_W'(63), 1'b1);
    send_item(OP_GROUP, BIT_W'(0), CHAR_W'(0), SIX_W'(0), 1'b1);
    send_item(OP_START, BIT_W'(12), CHAR_W'(255), SIX_W'(0), 1'b1);
    send_item(OP_GROUP, BIT_W'(1), CHAR_W'(1), SIX_W'(39), 1'b1);
    send_item(OP_GROUP, BIT_W'(1), CHAR_W'(1), SIX_W'(40), 1'b1);
  endtask

  // Oversized lengths are clamped; a new start abandons the open packet.
  task automatic test_clamp_and_abandon();
    send_packet(2047, "A", 3);
    send_packet(1025, "B", 2);
    send_packet(7, "B", groups_for(7));
  endtask

  // The receiver holds off while a two-sentence packet is pushed at full rate.
  task automatic test_back_pressure();
    sender_idle   = 0;
    receiver_idle = 0;
    hold_reqs++;
    send_packet(400, "A", groups_for(400));
  endtask

  task automatic test_full_rate();
    int bits;
    repeat (4) begin
      bits = pick_bits();
      send_packet(bits, pick_channel(), groups_for(bits));
    end
  endtask

  task automatic test_random_traffic();
    int kind;
    int bits;
    while (items_sent < ITEM_TARGET) begin
      sender_idle   = ($urandom_range(9) == 0) ? 0 : 25;
      receiver_idle = ($urandom_range(9) == 0) ? 0 : 25;
      kind = $urandom_range(99);
      bits = pick_bits();
      if (kind < 75) begin
        send_packet(bits, pick_channel(), groups_for(bits));
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(2, 1))
            send_item(OP_GROUP, BIT_W'($urandom_range(2047)), CHAR_W'($urandom_range(255)),
                      SIX_W'($urandom_range(63)), 1'b0);
      end else if (kind < 92) begin
        send_packet(bits, pick_channel(),
                    groups_for(bits) == 0 ? 0 : $urandom_range(groups_for(bits) - 1));
      end else begin
        send_item(OP_START, BIT_W'($urandom_range(2047)), CHAR_W'($urandom_range(255)),
                  SIX_W'($urandom_range(63)), 1'b1);
      end
    end
  endtask

  initial begin : stimulus
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_packets();
    test_clamp_and_abandon();
    test_back_pressure();
    test_full_rate();
    test_random_traffic();
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (sentence_chars_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sentence_chars_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected characters never arrived", $time, sentence_chars_q.size());
    end
    $display("Sent %0d packet starts, %0d payload groups and %0d stray groups.",
             starts_sent, groups_sent, strays_sent);
    $display("Checked %0d characters in %0d sentences, %0d packets closed, %0d mismatches.",
             chars_checked, sentences, packets_done, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("%0t: run timed out", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
